@@ src/fpba_pkg.sv @@
// shared types and constants for the fit-policy block allocator
// no dependencies; imported by fpba_ctrl, fpba_datapath and the top level

package fpba_pkg;

  // input transaction payload
  typedef struct packed {
    logic        operation;
    logic [6:0]  load_index;
    logic [15:0] size_value;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic        granted;
    logic [6:0]  chosen_block;
    logic [15:0] block_original_size;
    logic [15:0] block_remaining_size;
  } out_item_t;

  // operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // fit policy codes, anything else acts as first fit
  localparam logic [1:0] POLICY_WORST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_FIRST = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W         = 1;
  localparam int          CFG_DATA_W        = 8;
  localparam logic [0:0]  REG_FIT_POLICY    = 1'd0;
  localparam logic [0:0]  REG_BLOCKS_IN_USE = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take input transaction, clear scan state
    logic load_wr;   // write loaded size into both tables
    logic scan;      // issue next table read and evaluate previous one
    logic fetch;     // read original size, write back remaining size
    logic emit;      // load result register
  } fpba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_op;     // operation of the input transaction on the port
    logic scan_done; // every block in use read and evaluated
    logic out_free;  // result register can take a new result
  } fpba_status_t;

endpackage

@@ src/fpba_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies

module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/fpba_ctrl.sv @@
// sequencing state machine for the fit-policy block allocator
// depends on fpba_pkg for the command and status structs

module fpba_ctrl
  import fpba_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  fpba_status_t status,
  output fpba_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (status.in_op == OP_LOAD) ? S_LOAD : S_SCAN;
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/fpba_datapath.sv @@
// block tables, scan counter, fit selection, config and result registers
// depends on fpba_pkg and fpba_ram

module fpba_datapath
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 128,
  parameter int SIZE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              in_data,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  fpba_cmd_t             cmd,
  output fpba_status_t          status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam int AW    = (IDX_W > 7) ? IDX_W : 7;
  localparam int SW    = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  // configuration
  logic [1:0]            fit_policy;
  logic [CFG_DATA_W-1:0] blocks_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= POLICY_WORST;
      blocks_in_use <= CFG_DATA_W'(1);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_FIT_POLICY:    fit_policy    <= cfg_data[1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan limit saturates at the table depth
  logic [LIM_W-1:0] biu_wide;
  logic [CNT_W-1:0] limit;

  assign biu_wide = LIM_W'(blocks_in_use);
  assign limit    = (biu_wide > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_wide);

  // captured input
  logic [SW-1:0]        in_size_wide;
  logic [AW-1:0]        in_idx_wide;
  logic [SIZE_BITS-1:0] size_q;
  logic [IDX_W-1:0]     load_addr;
  logic                 load_ok;

  assign in_size_wide = SW'(in_data.size_value);
  assign in_idx_wide  = AW'(in_data.load_index);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      size_q    <= in_size_wide[SIZE_BITS-1:0];
      load_addr <= in_idx_wide[IDX_W-1:0];
      load_ok   <= (32'(in_data.load_index) < NUM_BLOCKS);
    end
  end

  // scan state
  logic [CNT_W-1:0]     cnt;
  logic                 pend;
  logic [IDX_W-1:0]     eval_idx;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best;
  logic                 issue;

  logic [SIZE_BITS-1:0] rem_rdata;
  logic [SIZE_BITS-1:0] orig_rdata;
  logic [SIZE_BITS-1:0] new_rem;
  logic                 fits;
  logic                 better;

  assign issue   = cmd.scan && (cnt < limit);
  assign new_rem = best - size_q;
  assign fits    = (rem_rdata >= size_q);

  always_comb begin
    case (fit_policy)
      POLICY_WORST: better = (rem_rdata > best);
      POLICY_BEST:  better = (rem_rdata < best);
      default:      better = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
    end else if (cmd.capture) begin
      pend  <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
    end else if (cmd.scan) begin
      pend <= issue;
      if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (pend && fits && (!found || better)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      eval_idx <= cnt[IDX_W-1:0];
    end
    if (cmd.scan && pend && fits && (!found || better)) begin
      pick <= eval_idx;
      best <= rem_rdata;
    end
  end

  // tables
  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_rem_ram (
    .clk     (clk),
    .wr_en   ((cmd.load_wr && load_ok) || (cmd.fetch && found)),
    .wr_addr (cmd.load_wr ? load_addr : pick),
    .wr_data (cmd.load_wr ? size_q : new_rem),
    .rd_en   (issue),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rem_rdata)
  );

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_orig_ram (
    .clk     (clk),
    .wr_en   (cmd.load_wr && load_ok),
    .wr_addr (load_addr),
    .wr_data (size_q),
    .rd_en   (cmd.fetch),
    .rd_addr (pick),
    .rd_data (orig_rdata)
  );

  // result register
  logic [AW-1:0] pick_wide;
  logic [SW-1:0] orig_wide;
  logic [SW-1:0] rem_wide;

  assign pick_wide = AW'(pick);
  assign orig_wide = SW'(orig_rdata);
  assign rem_wide  = SW'(new_rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.granted              <= found;
      out_data.chosen_block         <= found ? pick_wide[6:0] : 7'd0;
      out_data.block_original_size  <= found ? orig_wide[15:0] : 16'd0;
      out_data.block_remaining_size <= found ? rem_wide[15:0] : 16'd0;
    end
  end

  assign status.in_op     = in_data.operation;
  assign status.scan_done = (cnt >= limit) && !pend;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

@@ src/fit_policy_block_allocator.sv @@
// top level of the fit-policy block allocator: state machine plus datapath
// load: size written into both tables if load_index < NUM_BLOCKS; request: scan of the
// first blocks_in_use blocks (saturating at NUM_BLOCKS), fetch and write-back, result;
// the next transaction is accepted once the result loads, and a stalled result waits
// synchronous active-high reset clears control and config; tables stay undefined
// depends on fpba_pkg, fpba_ctrl, fpba_datapath, fpba_ram

module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = 128,
  parameter int SIZE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input transaction channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result transaction channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fpba_cmd_t    cmd;
  fpba_status_t status;

  // config writes land directly in the datapath registers
  assign cfg_ready = 1'b1;

  // sequencer: idle, load write, scan, fetch and write-back, result hand-off
  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // tables, best-candidate tracking and the result register
  fpba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
